### rtl/ssri_pkg.sv
// ----------------------------------------------------------------------------
// ssri_pkg
// Shared types and constants for the step schedule rate integrator.
// ----------------------------------------------------------------------------
package ssri_pkg;

  localparam int unsigned VW = 64;

  typedef logic [VW-1:0]   val_t;
  typedef logic [2*VW-1:0] prod_t;

  typedef struct packed {
    val_t h;
    val_t a;
  } entry_t;

  localparam logic       KIND_APPEND = 1'b0;
  localparam logic       KIND_QUERY  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_H    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENT,
    S_WAIT,
    S_TAIL,
    S_TWAIT,
    S_FIN,
    S_DONE
  } state_t;

endpackage

### rtl/ssri_cell.sv
// ----------------------------------------------------------------------------
// ssri_cell
// One breakpoint slot of the rotating ring: loads on a write, else takes its
// neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module ssri_cell
  import ssri_pkg::*;
(
  input  logic   clk,
  input  logic   shift,
  input  logic   wr,
  input  entry_t wr_ent,
  input  entry_t nb_ent,
  output entry_t ent
);

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (wr) begin
      ent_r <= wr_ent;
    end else if (shift) begin
      ent_r <= nb_ent;
    end
  end

  assign ent = ent_r;

endmodule

### rtl/ssri_mul.sv
// ----------------------------------------------------------------------------
// ssri_mul
// Sequential 64x64 multiplier: one 32x32 partial product per cycle, with the
// partial registered before it is added into the 128-bit sum.
// ----------------------------------------------------------------------------
module ssri_mul
  import ssri_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  val_t  op_a,
  input  val_t  op_b,
  output logic  done,
  output prod_t prod
);

  logic        busy_r, done_r, pv_r;
  logic [2:0]  step_r;
  logic [1:0]  sh_r;
  val_t        a_r, b_r;
  logic [63:0] part_r;
  prod_t       acc_r, part_sh;
  logic [31:0] ah, bh;

  assign ah = step_r[1] ? a_r[63:32] : a_r[31:0];
  assign bh = step_r[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    case (sh_r)
      2'd0:    part_sh = {64'd0, part_r};
      2'd3:    part_sh = {part_r, 64'd0};
      default: part_sh = {32'd0, part_r, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == 3'd4);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == 3'd4)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= op_a;
      b_r    <= op_b;
      step_r <= 3'd0;
      acc_r  <= '0;
      pv_r   <= 1'b0;
    end else if (busy_r) begin
      step_r <= step_r + 3'd1;
      part_r <= ah * bh;
      sh_r   <= step_r[1:0];
      pv_r   <= (step_r != 3'd4);
      if (pv_r) begin
        acc_r <= acc_r + part_sh;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### rtl/step_schedule_rate_integrator.sv
// ----------------------------------------------------------------------------
// step_schedule_rate_integrator
// Breakpoint table with spot rate, cumulative sum and schedule total queries.
// ----------------------------------------------------------------------------
// The breakpoints live in a ring of MAX_ENTRIES cells. A valid append item is
// written straight into the next free cell and its result passes through
// the S_DONE state into the output register. A query item rotates the ring
// once around: each stored entry passes the head cell, where two sequential
// 64x64 multipliers form the cumulative and the total span products, and
// each unused slot passes straight through. The multipliers issue one 32x32
// partial product per cycle. One item is in work at a time; the next one is
// taken as soon as the finished result moves to the output register, even
// while that result still waits to be taken.
// ----------------------------------------------------------------------------
module step_schedule_rate_integrator
  import ssri_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [63:0] in_height,
  input  logic [63:0] in_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_spot_amount,
  output logic [63:0] out_cumulative_amount,
  output logic        out_exact_match,
  output logic [4:0]  out_entry_count,
  output logic [63:0] out_schedule_total,
  output logic        out_total_valid
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, idx_r;
  logic [CW+4:0] cnt_ext;
  val_t          last_h_r;

  // Query working registers.
  logic   kind_r;
  logic [1:0] status_r;
  val_t   qh_r, qa_r;
  val_t   cum_r, from_c_r, rate_c_r, spot_r, tot_r, from_t_r, rate_t_r;
  logic   done_c_r, done_s_r, match_r, ovf_r;

  // Output register.
  logic       out_valid_r;
  logic [1:0] o_status_r;
  val_t       o_spot_r, o_cum_r, o_tot_r;
  logic       o_match_r, o_tvalid_r;
  logic [4:0] o_cnt_r;

  // Ring of cells; the head is cell 0.
  entry_t                 cell_q [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] wr_vec;
  entry_t                 wr_ent, head;
  logic                   ring_shift;

  logic  accept, app_bad, app_full, app_ok, has_entry, idx_last, tail_need;
  logic  mul_start, done_a, done_b;
  val_t  op_a_a, op_a_b, op_b_b, upto;
  prod_t prod_a, prod_b;
  val_t  tot_sum;
  logic  tot_carry;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  assign app_bad  = (in_height == '0) || ((count_r != '0) && (last_h_r >= in_height));
  assign app_full = (count_r >= CW'(MAX_ENTRIES));
  assign app_ok   = accept && (in_kind == KIND_APPEND) && !app_bad && !app_full;
  assign wr_ent   = '{h: in_height, a: in_amount};

  genvar k;
  generate
    for (k = 0; k < MAX_ENTRIES; k++) begin : g_ring
      localparam int unsigned NXT = (k + 1) % MAX_ENTRIES;
      assign wr_vec[k] = app_ok && (count_r == CW'(k));
      ssri_cell u_cell (
        .clk   (clk),
        .shift (ring_shift),
        .wr    (wr_vec[k]),
        .wr_ent(wr_ent),
        .nb_ent(cell_q[NXT]),
        .ent   (cell_q[k])
      );
    end
  endgenerate

  assign head      = cell_q[0];
  assign has_entry = (idx_r < count_r);
  assign idx_last  = (idx_r == CW'(MAX_ENTRIES - 1));
  assign tail_need = (from_c_r < qh_r);
  assign upto      = (qh_r < head.h) ? qh_r : head.h;

  // In the tail step the cumulative multiplier covers the span past the last
  // breakpoint seen; otherwise it covers the span up to the head entry.
  assign op_a_a = rate_c_r;
  assign op_a_b = (state_r == S_TAIL) ? (qh_r - from_c_r) : (upto - from_c_r);
  assign op_b_b = head.h - from_t_r;

  ssri_mul u_mul_cum (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .op_a (op_a_a),
    .op_b (op_a_b),
    .done (done_a),
    .prod (prod_a)
  );

  ssri_mul u_mul_tot (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start && (state_r == S_ENT)),
    .op_a (rate_t_r),
    .op_b (op_b_b),
    .done (done_b),
    .prod (prod_b)
  );

  assign {tot_carry, tot_sum} = {1'b0, tot_r} + {1'b0, prod_b[63:0]};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_kind == KIND_QUERY) ? S_ENT : S_DONE;
        end
      end
      S_ENT: begin
        if (has_entry) begin
          state_nxt = S_WAIT;
        end else if (idx_last) begin
          state_nxt = S_TAIL;
        end
      end
      S_WAIT: begin
        if (done_a) begin
          state_nxt = idx_last ? S_TAIL : S_ENT;
        end
      end
      S_TAIL:  state_nxt = tail_need ? S_TWAIT : S_FIN;
      S_TWAIT: begin
        if (done_a) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN:   state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    mul_start  = 1'b0;
    ring_shift = 1'b0;
    case (state_r)
      S_ENT: begin
        mul_start  = has_entry;
        ring_shift = !has_entry;
      end
      S_WAIT:  ring_shift = done_a;
      S_TAIL:  mul_start  = tail_need;
      default: begin
        mul_start  = 1'b0;
        ring_shift = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (app_ok) begin
        count_r <= count_r + CW'(1);
      end
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (app_ok) begin
      last_h_r <= in_height;
    end
    if (accept) begin
      kind_r   <= in_kind;
      qh_r     <= in_height;
      qa_r     <= in_amount;
      status_r <= (in_kind == KIND_QUERY) ? ST_OK : (app_bad ? ST_BAD_H :
                  (app_full ? ST_FULL : ST_OK));
      cum_r    <= '0;
      from_c_r <= 64'd1;
      rate_c_r <= '0;
      done_c_r <= 1'b0;
      spot_r   <= '0;
      done_s_r <= 1'b0;
      match_r  <= 1'b0;
      tot_r    <= '0;
      from_t_r <= 64'd1;
      rate_t_r <= '0;
      ovf_r    <= 1'b0;
      idx_r    <= '0;
    end
    if (ring_shift) begin
      idx_r <= idx_r + CW'(1);
    end
    if ((state_r == S_WAIT) && done_a) begin
      if (!done_c_r) begin
        cum_r    <= cum_r + prod_a[63:0];
        from_c_r <= head.h;
        rate_c_r <= head.a;
        done_c_r <= (qh_r <= head.h);
      end
      if (!done_s_r) begin
        if (qh_r < head.h) begin
          done_s_r <= 1'b1;
        end else begin
          spot_r <= head.a;
        end
      end
      if ((head.h == qh_r) && (head.a == qa_r)) begin
        match_r <= 1'b1;
      end
      if (!ovf_r) begin
        if ((prod_b[127:64] != '0) || tot_carry) begin
          ovf_r <= 1'b1;
        end else begin
          tot_r <= tot_sum;
        end
      end
      from_t_r <= head.h;
      rate_t_r <= head.a;
    end
    if ((state_r == S_TWAIT) && done_a) begin
      cum_r <= cum_r + prod_a[63:0];
    end
  end

  assign cnt_ext = {5'd0, count_r};

  // Output register load: an append carries only status and count.
  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      o_status_r <= status_r;
      o_cnt_r    <= cnt_ext[4:0];
      if (kind_r == KIND_QUERY) begin
        o_spot_r   <= spot_r;
        o_cum_r    <= (qh_r == '0) ? '0 : cum_r;
        o_match_r  <= match_r;
        o_tot_r    <= (!ovf_r && (rate_t_r == '0)) ? tot_r : '0;
        o_tvalid_r <= !ovf_r && (rate_t_r == '0);
      end else begin
        o_spot_r   <= '0;
        o_cum_r    <= '0;
        o_match_r  <= 1'b0;
        o_tot_r    <= '0;
        o_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = o_status_r;
  assign out_spot_amount       = o_spot_r;
  assign out_cumulative_amount = o_cum_r;
  assign out_exact_match       = o_match_r;
  assign out_entry_count       = o_cnt_r;
  assign out_schedule_total    = o_tot_r;
  assign out_total_valid       = o_tvalid_r;

  // The total multiplier is only started together with the cumulative one, so the two must finish together.
  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    done_b |-> done_a)
    else $error("total multiplier finished out of step");

  // A multiplier result only arrives while the sequencer waits for one.
  a_mul_expected: assert property (@(posedge clk) disable iff (!rst_n)
    done_a |-> ((state_r == S_WAIT) || (state_r == S_TWAIT)))
    else $error("multiplier result arrived unexpectedly");

  // The table never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  // A query always enters the ring walk next.
  a_query_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_QUERY)) |=> (state_r == S_ENT))
    else $error("query did not start the ring walk");

endmodule
